// File: hw/rtl/chtab_pkg.sv
// Package for the chained hash table: transaction structs, operation and
// status codes, state machine type and the bucket index function.
// No dependencies.
package chtab_pkg;

  localparam int BYTE_SHIFT = 3;
  localparam int BUCKET_MAX_W = 24;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  entry_handle;
    logic [63:0] key;
  } cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] found_handle;
  } rsp_t;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_LOOKUP,
    OP_REFUSE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  entry_handle;
    logic [63:0] key;
    logic [1:0]  index_bytes;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_INS_WR,
    S_INS_LINK,
    S_REM_CHK,
    S_REM_HEAD,
    S_LK_HEAD,
    S_LK_CMP
  } back_state_t;

  // Low index_bytes*8 key bits, the width held between 8 and max_bits.
  function automatic logic [BUCKET_MAX_W-1:0] bucket_of(logic [63:0] key,
                                                        logic [1:0] idx,
                                                        int max_bits);
    int bits;
    logic [BUCKET_MAX_W:0] mask;
    bits = int'(idx) << BYTE_SHIFT;
    if (bits < 8) bits = 8;
    if (bits > max_bits) bits = max_bits;
    mask = ({{BUCKET_MAX_W{1'b0}}, 1'b1} << bits) - {{BUCKET_MAX_W{1'b0}}, 1'b1};
    return key[BUCKET_MAX_W-1:0] & mask[BUCKET_MAX_W-1:0];
  endfunction

endpackage

// File: hw/rtl/chtab_front.sv
// Front end: classifies an incoming command into a queued operation.
// Depends on chtab_pkg.
module chtab_front import chtab_pkg::*; #(
  parameter int POOL_ENTRIES = 256
) (
  input  cmd_t       cmd,
  input  logic [1:0] index_bytes,
  output item_t      item
);

  logic handle_ok;

  assign handle_ok = 32'(cmd.entry_handle) < 32'(POOL_ENTRIES);

  always_comb begin
    item.entry_handle = cmd.entry_handle;
    item.key          = cmd.key;
    item.index_bytes  = index_bytes;
    unique case (cmd.func)
      FN_INSERT: item.op = handle_ok ? OP_INSERT : OP_REFUSE;
      FN_REMOVE: item.op = handle_ok ? OP_REMOVE : OP_REFUSE;
      FN_LOOKUP: item.op = OP_LOOKUP;
      default:   item.op = OP_REFUSE;
    endcase
  end

endmodule

// File: hw/rtl/chtab_queue.sv
// Two-entry queue between the front end and the back end.
// Depends on chtab_pkg.
module chtab_queue import chtab_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   pop_item,
  output q_stat_t stat
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  assign pop_item   = slots[rd_ptr];
  assign stat.full  = count == 2'd2;
  assign stat.empty = count == 2'd0;

endmodule

// File: hw/rtl/chtab_back.sv
// Back end: sequencer over the head, key and link memories that carries out
// insert, remove and lookup, and clears the head table after reset.
// Depends on chtab_pkg.
module chtab_back import chtab_pkg::*; #(
  parameter int POOL_ENTRIES   = 256,
  parameter int MAX_INDEX_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  q_stat_t    q_stat,
  input  item_t      q_item,
  output logic       pop,
  output logic       result_valid,
  output rsp_t       result,
  output back_stat_t stat
);

  localparam int HW     = $clog2(POOL_ENTRIES);
  localparam int LW     = HW + 1;
  localparam int BW     = MAX_INDEX_BITS;
  localparam int BUCKETS = 1 << BW;

  localparam logic [LW-1:0] NULL_LINK = {1'b1, {HW{1'b0}}};

  back_state_t state, state_next;

  logic [LW-1:0] heads_mem [BUCKETS];
  logic [63:0]   keys_mem  [POOL_ENTRIES];
  logic [LW-1:0] next_mem  [POOL_ENTRIES];
  logic [LW-1:0] prev_mem  [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0] linked;

  logic [LW-1:0] heads_rd, next_rd, prev_rd;
  logic [63:0]   key_rd;

  logic [BW-1:0] clr_cnt;
  op_t           op;
  logic [HW-1:0] h;
  logic [63:0]   key;
  logic [1:0]    idx;
  logic [LW-1:0] ins_head, rem_nx;
  logic [BW-1:0] rem_b;
  logic [HW-1:0] cur;
  logic [HW-1:0] steps;

  logic [BW-1:0] b_cur, b_rd;
  logic          head_we, key_we, next_we, prev_we, link_set, link_clr;
  logic [BW-1:0] head_wa, heads_ra;
  logic [LW-1:0] head_wd, next_wd, prev_wd;
  logic [HW-1:0] next_wa, prev_wa, ent_ra;
  logic          emit;
  logic [1:0]    emit_status;
  logic [7:0]    emit_found;

  assign b_cur = BW'(bucket_of(key, idx, MAX_INDEX_BITS));
  assign b_rd  = BW'(bucket_of(key_rd, idx, MAX_INDEX_BITS));

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_found  = 8'd0;
    head_we     = 1'b0;
    head_wa     = b_cur;
    head_wd     = {1'b0, h};
    heads_ra    = b_cur;
    key_we      = 1'b0;
    next_we     = 1'b0;
    next_wa     = h;
    next_wd     = heads_rd;
    prev_we     = 1'b0;
    prev_wa     = h;
    prev_wd     = NULL_LINK;
    ent_ra      = h;
    link_set    = 1'b0;
    link_clr    = 1'b0;
    unique case (state)
      S_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_cnt;
        head_wd = NULL_LINK;
        if (clr_cnt == '1) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (op)
          OP_INSERT: begin
            if (linked[h]) begin
              emit        = 1'b1;
              emit_status = ST_REFUSED;
              state_next  = S_IDLE;
            end else begin
              state_next = S_INS_WR;
            end
          end
          OP_REMOVE: begin
            if (!linked[h]) begin
              emit        = 1'b1;
              emit_status = ST_REFUSED;
              state_next  = S_IDLE;
            end else begin
              state_next = S_REM_CHK;
            end
          end
          OP_LOOKUP: state_next = S_LK_HEAD;
          default: begin
            emit        = 1'b1;
            emit_status = ST_REFUSED;
            state_next  = S_IDLE;
          end
        endcase
      end
      S_INS_WR: begin
        // The new entry goes to the front; the old head is back-linked next.
        key_we     = 1'b1;
        next_we    = 1'b1;
        prev_we    = 1'b1;
        head_we    = 1'b1;
        link_set   = 1'b1;
        state_next = S_INS_LINK;
      end
      S_INS_LINK: begin
        if (!ins_head[HW]) begin
          prev_we = 1'b1;
          prev_wa = ins_head[HW-1:0];
          prev_wd = {1'b0, h};
        end
        emit       = 1'b1;
        state_next = S_IDLE;
      end
      S_REM_CHK: begin
        if (prev_rd[HW]) begin
          heads_ra   = b_rd;
          state_next = S_REM_HEAD;
        end else begin
          next_we = 1'b1;
          next_wa = prev_rd[HW-1:0];
          next_wd = next_rd;
          if (!next_rd[HW]) begin
            prev_we = 1'b1;
            prev_wa = next_rd[HW-1:0];
            prev_wd = prev_rd;
          end
          link_clr   = 1'b1;
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REM_HEAD: begin
        // A front entry that is not the head of its present bucket is stale.
        if (heads_rd == {1'b0, h}) begin
          head_we = 1'b1;
          head_wa = rem_b;
          head_wd = rem_nx;
          if (!rem_nx[HW]) begin
            prev_we = 1'b1;
            prev_wa = rem_nx[HW-1:0];
            prev_wd = NULL_LINK;
          end
          link_clr = 1'b1;
        end else begin
          emit_status = ST_REFUSED;
        end
        emit       = 1'b1;
        state_next = S_IDLE;
      end
      S_LK_HEAD: begin
        ent_ra = heads_rd[HW-1:0];
        if (heads_rd[HW]) begin
          emit        = 1'b1;
          emit_status = ST_MISS;
          state_next  = S_IDLE;
        end else begin
          state_next = S_LK_CMP;
        end
      end
      S_LK_CMP: begin
        ent_ra = next_rd[HW-1:0];
        if (key_rd == key) begin
          emit       = 1'b1;
          emit_found = 8'(cur);
          state_next = S_IDLE;
        end else if (next_rd[HW] ||
                     (32'(steps) + 32'd1 >= 32'(POOL_ENTRIES))) begin
          emit        = 1'b1;
          emit_status = ST_MISS;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op  <= q_item.op;
      h   <= HW'(q_item.entry_handle);
      key <= q_item.key;
      idx <= q_item.index_bytes;
    end
    if (state == S_INS_WR) ins_head <= heads_rd;
    if (state == S_REM_CHK) begin
      rem_nx <= next_rd;
      rem_b  <= b_rd;
    end
    if (state == S_LK_HEAD) begin
      cur   <= heads_rd[HW-1:0];
      steps <= '0;
    end else if (state == S_LK_CMP) begin
      cur   <= next_rd[HW-1:0];
      steps <= steps + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) linked <= '0;
    else if (link_set) linked[h] <= 1'b1;
    else if (link_clr) linked[h] <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (head_we) heads_mem[head_wa] <= head_wd;
    heads_rd <= heads_mem[heads_ra];
  end

  always_ff @(posedge clk) begin
    if (key_we) keys_mem[h] <= key;
    key_rd <= keys_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd <= next_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    prev_rd <= prev_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= emit;
    result.status       <= emit_status;
    result.found_handle <= emit_found;
  end

  assign stat.clearing = state == S_CLEAR;

endmodule

// File: hw/rtl/chained_hash_table.sv
// Top level of the chained hash table: configuration register, front end,
// queue and back end. Depends on chtab_pkg, chtab_front, chtab_queue and
// chtab_back.
//
//   channel   signals                      transaction
//   command   start, busy, cmd             start && !busy
//   result    result_valid, result         result_valid, one cycle, no stall
//   config    cfg_valid, cfg_ready, cfg_data  cfg_valid && cfg_ready
//
// The back-end sequencer takes an insert through dispatch, write and link,
// a remove through check and, when the entry heads its chain, head, and a
// lookup through head and one compare per entry walked; a command refused
// for its function, handle or link state is answered from dispatch.
// After reset the head table is cleared with busy high. The two-entry queue
// lets commands be taken while the back end works; busy rises only when it
// is full or the head table is being cleared. Results cannot be held off.
module chained_hash_table import chtab_pkg::*; #(
  parameter int POOL_ENTRIES   = 256,
  parameter int MAX_INDEX_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  cmd_t       cmd,
  output logic       result_valid,
  output rsp_t       result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  logic       [1:0] index_bytes;
  item_t      front_item, q_item;
  q_stat_t    q_stat;
  back_stat_t b_stat;
  logic       pop;
  logic       push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) index_bytes <= 2'd1;
    else if (cfg_valid && cfg_ready) index_bytes <= cfg_data;
  end

  assign busy = q_stat.full || b_stat.clearing;
  assign push = start && !busy;

  chtab_front #(.POOL_ENTRIES(POOL_ENTRIES)) u_front (
    .cmd         (cmd),
    .index_bytes (index_bytes),
    .item        (front_item)
  );

  chtab_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .pop_item  (q_item),
    .stat      (q_stat)
  );

  chtab_back #(
    .POOL_ENTRIES   (POOL_ENTRIES),
    .MAX_INDEX_BITS (MAX_INDEX_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .q_item       (q_item),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result),
    .stat         (b_stat)
  );

  a_found_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_OK |-> result.found_handle == 8'd0)
    else $error("found handle set on a result that is not a hit");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> busy)
    else $error("block not busy clearing after reset");

  a_result_spacing: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("results on two consecutive cycles");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("back end took an item from an empty queue");

endmodule

// File: tb/tb_chained_hash_table.sv
// Self-checking testbench for chained_hash_table: a directed table, then random
// insert/remove/lookup and bad-function traffic under several index widths, checked against a predictor.
// Depends on chtab_pkg and the chained_hash_table RTL.
module tb_chained_hash_table;
  import chtab_pkg::*;

  localparam int N_ENTRIES = 256;
  localparam int N_BUCKETS = 65536;
  localparam int IDX_MAX_BITS = 16;
  localparam int DRAIN_CYCLES = 300;
  localparam logic [1:0] FN_BAD = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic result_valid;
  rsp_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = 2'd0;

  chained_hash_table dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow of the table: bit 8 of a link or head is the empty flag.
  logic [8:0]  head_tab [N_BUCKETS];
  logic [63:0] key_tab  [N_ENTRIES];
  logic [8:0]  next_tab [N_ENTRIES];
  logic [8:0]  prev_tab [N_ENTRIES];
  logic        on_chain [N_ENTRIES];
  logic [1:0]  idx_bytes;

  rsp_t pending_rsp [$];
  int   mismatches = 0;
  int   idle_pct = 0;
  logic [63:0] key_pool [32];

  function automatic int bucket_index(logic [63:0] k);
    int bits;
    bits = int'(idx_bytes) * 8;
    if (bits < 8) bits = 8;
    if (bits > IDX_MAX_BITS) bits = IDX_MAX_BITS;
    return int'(k & ((64'd1 << bits) - 64'd1));
  endfunction

  function automatic rsp_t table_response(cmd_t c);
    rsp_t r;
    int b;
    int h;
    logic [8:0] nx;
    logic [8:0] pv;
    logic [8:0] cur;
    r = '0;
    h = int'(c.entry_handle);
    case (c.func)
      FN_INSERT: begin
        if (on_chain[h]) begin
          r.status = ST_REFUSED;
        end else begin
          b = bucket_index(c.key);
          key_tab[h] = c.key;
          next_tab[h] = head_tab[b];
          prev_tab[h] = 9'h100;
          if (!head_tab[b][8]) prev_tab[head_tab[b][7:0]] = 9'(h);
          head_tab[b] = 9'(h);
          on_chain[h] = 1'b1;
          r.status = ST_OK;
        end
      end
      FN_REMOVE: begin
        r.status = ST_OK;
        if (!on_chain[h]) begin
          r.status = ST_REFUSED;
        end else begin
          b = bucket_index(key_tab[h]);
          nx = next_tab[h];
          pv = prev_tab[h];
          // A front entry whose bucket moved with the index width is left alone.
          if (pv[8] && head_tab[b] != 9'(h)) begin
            r.status = ST_REFUSED;
          end else begin
            if (pv[8]) head_tab[b] = nx;
            else next_tab[pv[7:0]] = nx;
            if (!nx[8]) prev_tab[nx[7:0]] = pv;
            next_tab[h] = 9'h100;
            prev_tab[h] = 9'h100;
            on_chain[h] = 1'b0;
          end
        end
      end
      FN_LOOKUP: begin
        r.status = ST_MISS;
        cur = head_tab[bucket_index(c.key)];
        for (int s = 0; s < N_ENTRIES; s++) begin
          if (cur[8] || r.status == ST_OK) break;
          if (key_tab[cur[7:0]] == c.key) begin
            r.status = ST_OK;
            r.found_handle = cur[7:0];
          end else begin
            cur = next_tab[cur[7:0]];
          end
        end
      end
      default: r.status = ST_REFUSED;
    endcase
    return r;
  endfunction

  // Hand one command over; the expectation is queued at the accepting edge.
  task automatic issue(cmd_t c, bit typed, rsp_t typed_rsp);
    rsp_t r;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    cmd = c;
    do @(posedge clk); while (busy);
    r = table_response(c);
    pending_rsp.push_back(typed ? typed_rsp : r);
  endtask

  task automatic set_index_bytes(logic [1:0] v);
    @(negedge clk);
    start = 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    idx_bytes = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d/%0d",
                                       result.status, result.found_handle);
      end else begin
        rsp_t e;
        e = pending_rsp.pop_front();
        if (e.status !== result.status || e.found_handle !== result.found_handle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected status %0d handle %0d, got %0d %0d",
                     e.status, e.found_handle, result.status, result.found_handle);
        end
      end
    end
  end

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  handle;
    logic [63:0] key;
    bit          typed;
    logic [1:0]  status;
    logic [7:0]  found;
  } row_t;

  row_t directed [] = '{
    '{FN_LOOKUP, 8'd0,   64'd0,  1, ST_MISS,    8'd0},
    '{FN_REMOVE, 8'd3,   64'd0,  1, ST_REFUSED, 8'd0},
    '{FN_INSERT, 8'd0,   64'd0,  1, ST_OK,      8'd0},
    '{FN_INSERT, 8'd255, '1,     1, ST_OK,      8'd0},
    '{FN_INSERT, 8'd0,   64'd7,  1, ST_REFUSED, 8'd0},
    '{FN_LOOKUP, 8'd9,   64'd0,  1, ST_OK,      8'd0},
    '{FN_LOOKUP, 8'd0,   '1,     1, ST_OK,      8'd255},
    '{FN_BAD,    8'd255, '1,     1, ST_REFUSED, 8'd0},
    '{FN_INSERT, 8'd1,   64'h100, 0, 0, 0},
    '{FN_INSERT, 8'd2,   64'd0,  0, 0, 0},
    '{FN_LOOKUP, 8'd0,   64'd0,  1, ST_OK,      8'd2},
    '{FN_LOOKUP, 8'd0,   64'h100, 0, 0, 0},
    '{FN_REMOVE, 8'd1,   64'd0,  0, 0, 0},
    '{FN_REMOVE, 8'd2,   64'd0,  0, 0, 0},
    '{FN_LOOKUP, 8'd0,   64'd0,  1, ST_OK,      8'd0},
    '{FN_REMOVE, 8'd255, 64'd0,  1, ST_OK,      8'd0},
    '{FN_LOOKUP, 8'd0,   '1,     1, ST_MISS,    8'd0},
    '{FN_REMOVE, 8'd255, 64'd0,  1, ST_REFUSED, 8'd0},
    '{FN_INSERT, 8'd5,   64'h1234, 1, ST_OK,    8'd0}
  };

  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    pick = $urandom_range(99);
    c.entry_handle = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(47));
    c.key = key_pool[$urandom_range(31)];
    if ($urandom_range(19) == 0) c.key = {$urandom, $urandom};
    if (pick < 40) c.func = FN_INSERT;
    else if (pick < 68) c.func = FN_REMOVE;
    else if (pick < 96) c.func = FN_LOOKUP;
    else c.func = FN_BAD;
    return c;
  endfunction

  logic [1:0] phase_idx [6] = '{2'd2, 2'd0, 2'd3, 2'd1, 2'd2, 2'd1};
  int phase_idle [6] = '{14, 84, 0, 14, 84, 0};

  initial begin
    cmd_t c;
    rsp_t t;
    idx_bytes = 2'd1;
    for (int i = 0; i < N_BUCKETS; i++) head_tab[i] = 9'h100;
    for (int i = 0; i < N_ENTRIES; i++) begin
      key_tab[i] = '0;
      next_tab[i] = 9'h100;
      prev_tab[i] = 9'h100;
      on_chain[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) begin
      c.func = directed[i].func;
      c.entry_handle = directed[i].handle;
      c.key = directed[i].key;
      t.status = directed[i].status;
      t.found_handle = directed[i].found;
      issue(c, directed[i].typed, t);
    end
    // Entry 5 now sits in the wrong bucket for a two-byte index.
    set_index_bytes(2'd2);
    c = '{FN_REMOVE, 8'd5, 64'd0};
    t = '{ST_REFUSED, 8'd0};
    issue(c, 1, t);

    for (int p = 0; p < 6; p++) begin
      set_index_bytes(phase_idx[p]);
      idle_pct = phase_idle[p];
      // Few low-byte patterns so chains grow long and removes hit mid-chain.
      for (int k = 0; k < 32; k++)
        key_pool[k] = {$urandom, $urandom_range(65535) < 8000 ? 16'h0
                       : 16'($urandom_range(3)), 16'($urandom_range(7) << 4)};
      for (int n = 0; n < 325; n++) issue(random_cmd(), 0, t);
    end
    @(negedge clk);
    start = 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0)
      $display("chained_hash_table: match");
    else
      $display("chained_hash_table: mismatch");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("chained_hash_table: mismatch");
    $finish;
  end

endmodule

// File: chained_hash_table.f
hw/rtl/chtab_pkg.sv
hw/rtl/chtab_front.sv
hw/rtl/chtab_queue.sv
hw/rtl/chtab_back.sv
hw/rtl/chained_hash_table.sv
tb/tb_chained_hash_table.sv
